/* rtl/rtnh_pkg.sv */
// ----------------------------------------------------------------------------
// rtnh_pkg: shared types and constants of the ray / triangle nearest hit unit
// Widths, register indexes, controller states and the command and status
// groups that pass between controller and datapath.
// ----------------------------------------------------------------------------
package rtnh_pkg;

	localparam int COORD_WIDTH    = 16;
	localparam int DIST_FRAC_BITS = 16;
	localparam int EW             = COORD_WIDTH + 1;   // edge, tvec and direction
	localparam int PW             = 2 * EW;            // cross product terms
	localparam int MW             = EW + PW;           // multiplier product
	localparam int ACCW           = 64;                // accumulator, Q40.24
	localparam int DW             = 32;                // distance width
	localparam int IW             = DW - DIST_FRAC_BITS;
	localparam int EPSW           = 48;
	localparam int NSTEP          = 24;                // multiply steps per triangle
	localparam int STEPW          = 5;
	localparam int CFG_IDXW       = 3;

	localparam logic [DW-1:0] NO_HIT   = {DW{1'b1}};
	localparam logic [DW-1:0] DIST_SAT = {{(DW-1){1'b1}}, 1'b0};

	typedef enum logic [CFG_IDXW-1:0] {
		CFG_ORIGIN_X = 3'd0,
		CFG_ORIGIN_Y = 3'd1,
		CFG_ORIGIN_Z = 3'd2,
		CFG_DIR_X    = 3'd3,
		CFG_DIR_Y    = 3'd4,
		CFG_DIR_Z    = 3'd5,
		CFG_DET_EPS  = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] origin_x;
		logic signed [COORD_WIDTH-1:0] origin_y;
		logic signed [COORD_WIDTH-1:0] origin_z;
		logic signed [COORD_WIDTH-1:0] dir_x;
		logic signed [COORD_WIDTH-1:0] dir_y;
		logic signed [COORD_WIDTH-1:0] dir_z;
		logic [EPSW-1:0]               det_epsilon;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SIGN,
		ST_CHECK,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic             load;
		logic             mul_en;
		logic             acc_en;
		logic [STEPW-1:0] mul_step;
		logic [STEPW-1:0] acc_step;
		logic             sign_en;
		logic             check_en;
		logic             div_step;
		logic             finish;
	} cmd_t;

	typedef struct packed {
		logic hit;
		logic sat;
		logic out_free;
	} sts_t;

endpackage

/* rtl/ray_triangle_nearest_hit_unit.sv */
// ----------------------------------------------------------------------------
// ray_triangle_nearest_hit_unit: ray / triangle intersection, nearest hit
// Tests the configured ray against a stream of triangles and tracks the
// nearest hit distance since the last restart.
// ----------------------------------------------------------------------------
// usage:
//   cfg channel: write origin, direction and det threshold by index while
//     no triangle is in flight; cfg_ready is always high.
//   in channel: one triangle request (three Q8.8 vertices and restart) per
//     handshake; in_ready is high only while the unit is idle.
//   out channel: one result per triangle in a holding register, so the next
//     triangle is taken while the previous result waits.
// sequence: one shared 17x34 multiplier does the 24 products in turn,
//   then sign fix and hit test follow; an unsaturated hit runs a 32-step
//   restoring divider, which a miss or saturated distance skips. The next
//   triangle is accepted once the unit is back in idle.
// reset: ray goes to origin with +z direction, nearest distance to no hit.
// a stalled receiver holds the unit in its final state until the output
//   register frees up; nothing is dropped.
// ----------------------------------------------------------------------------
module ray_triangle_nearest_hit_unit (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [rtnh_pkg::CFG_IDXW-1:0]           cfg_index,
	input  logic [rtnh_pkg::EPSW-1:0]               cfg_data,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic                                    restart,
	input  logic signed [rtnh_pkg::COORD_WIDTH-1:0] v0_x,
	input  logic signed [rtnh_pkg::COORD_WIDTH-1:0] v0_y,
	input  logic signed [rtnh_pkg::COORD_WIDTH-1:0] v0_z,
	input  logic signed [rtnh_pkg::COORD_WIDTH-1:0] v1_x,
	input  logic signed [rtnh_pkg::COORD_WIDTH-1:0] v1_y,
	input  logic signed [rtnh_pkg::COORD_WIDTH-1:0] v1_z,
	input  logic signed [rtnh_pkg::COORD_WIDTH-1:0] v2_x,
	input  logic signed [rtnh_pkg::COORD_WIDTH-1:0] v2_y,
	input  logic signed [rtnh_pkg::COORD_WIDTH-1:0] v2_z,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic                                    triangle_hit,
	output logic [rtnh_pkg::DW-1:0]                 triangle_distance,
	output logic [rtnh_pkg::DW-1:0]                 nearest_distance,
	output logic                                    any_hit
);
	import rtnh_pkg::*;

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	rtnh_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rtnh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rtnh_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg),
		.cmd               (cmd),
		.sts               (sts),
		.restart           (restart),
		.v0_x              (v0_x),
		.v0_y              (v0_y),
		.v0_z              (v0_z),
		.v1_x              (v1_x),
		.v1_y              (v1_y),
		.v1_z              (v1_z),
		.v2_x              (v2_x),
		.v2_y              (v2_y),
		.v2_z              (v2_z),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.triangle_hit      (triangle_hit),
		.triangle_distance (triangle_distance),
		.nearest_distance  (nearest_distance),
		.any_hit           (any_hit)
	);

endmodule

/* rtl/rtnh_cfg.sv */
// ----------------------------------------------------------------------------
// rtnh_cfg: ray configuration registers
// Holds origin, direction and determinant threshold; writes beyond the
// register list are dropped.
// ----------------------------------------------------------------------------
module rtnh_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic [rtnh_pkg::CFG_IDXW-1:0]  cfg_index,
	input  logic [rtnh_pkg::EPSW-1:0]      cfg_data,
	output rtnh_pkg::cfg_t                 cfg
);
	import rtnh_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x    <= '0;
			cfg_q.origin_y    <= '0;
			cfg_q.origin_z    <= '0;
			cfg_q.dir_x       <= '0;
			cfg_q.dir_y       <= '0;
			cfg_q.dir_z       <= COORD_WIDTH'(256);
			cfg_q.det_epsilon <= EPSW'(17);
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ORIGIN_X: cfg_q.origin_x    <= cfg_data[COORD_WIDTH-1:0];
				CFG_ORIGIN_Y: cfg_q.origin_y    <= cfg_data[COORD_WIDTH-1:0];
				CFG_ORIGIN_Z: cfg_q.origin_z    <= cfg_data[COORD_WIDTH-1:0];
				CFG_DIR_X:    cfg_q.dir_x       <= cfg_data[COORD_WIDTH-1:0];
				CFG_DIR_Y:    cfg_q.dir_y       <= cfg_data[COORD_WIDTH-1:0];
				CFG_DIR_Z:    cfg_q.dir_z       <= cfg_data[COORD_WIDTH-1:0];
				CFG_DET_EPS:  cfg_q.det_epsilon <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/rtnh_ctrl.sv */
// ----------------------------------------------------------------------------
// rtnh_ctrl: sequencer of the nearest hit unit
// Steps the shared multiplier through the cross and dot products, then the
// sign fix, hit check, bit-serial division and result hand-off.
// ----------------------------------------------------------------------------
module rtnh_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  rtnh_pkg::sts_t sts,
	output rtnh_pkg::cmd_t cmd
);
	import rtnh_pkg::*;

	state_t           state_q, state_d;
	logic [STEPW-1:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		case (state_q)
			ST_IDLE: begin
				cnt_d = '0;
				if (in_valid) state_d = ST_MUL;
			end
			ST_MUL: begin
				if (cnt_q == STEPW'(NSTEP)) begin
					state_d = ST_SIGN;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_SIGN: state_d = ST_CHECK;
			ST_CHECK: begin
				cnt_d = '0;
				// miss or saturated distance skips the divider
				if (sts.hit && !sts.sat) begin
					state_d = ST_DIV;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_DIV: begin
				if (cnt_q == STEPW'(DW - 1)) begin
					state_d = ST_FIN;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_FIN: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.mul_step = cnt_q;
		cmd.acc_step = cnt_q - 1'b1;
		in_ready     = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE:  cmd.load = in_valid;
			ST_MUL: begin
				cmd.mul_en = (cnt_q != STEPW'(NSTEP));
				cmd.acc_en = (cnt_q != '0);
			end
			ST_SIGN:  cmd.sign_en  = 1'b1;
			ST_CHECK: cmd.check_en = 1'b1;
			ST_DIV:   cmd.div_step = 1'b1;
			ST_FIN:   cmd.finish   = sts.out_free;
			default: ;
		endcase
	end

	a_load_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == ST_MUL) && (cnt_q == '0))
		else $error("load did not start the multiply sequence");

	a_div_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_DIV) |-> $past(sts.hit && !sts.sat))
		else $error("divider started without an unsaturated hit");

	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> sts.out_free)
		else $error("result written while output register busy");

endmodule

/* rtl/rtnh_dp.sv */
// ----------------------------------------------------------------------------
// rtnh_dp: datapath of the nearest hit unit
// Edge registers, one shared multiplier with accumulator, sign fix and hit
// test, restoring divider, nearest-hit state and output register.
// ----------------------------------------------------------------------------
module rtnh_dp (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  rtnh_pkg::cfg_t                          cfg,
	input  rtnh_pkg::cmd_t                          cmd,
	output rtnh_pkg::sts_t                          sts,
	input  logic                                    restart,
	input  logic signed [rtnh_pkg::COORD_WIDTH-1:0] v0_x,
	input  logic signed [rtnh_pkg::COORD_WIDTH-1:0] v0_y,
	input  logic signed [rtnh_pkg::COORD_WIDTH-1:0] v0_z,
	input  logic signed [rtnh_pkg::COORD_WIDTH-1:0] v1_x,
	input  logic signed [rtnh_pkg::COORD_WIDTH-1:0] v1_y,
	input  logic signed [rtnh_pkg::COORD_WIDTH-1:0] v1_z,
	input  logic signed [rtnh_pkg::COORD_WIDTH-1:0] v2_x,
	input  logic signed [rtnh_pkg::COORD_WIDTH-1:0] v2_y,
	input  logic signed [rtnh_pkg::COORD_WIDTH-1:0] v2_z,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic                                    triangle_hit,
	output logic [rtnh_pkg::DW-1:0]                 triangle_distance,
	output logic [rtnh_pkg::DW-1:0]                 nearest_distance,
	output logic                                    any_hit
);
	import rtnh_pkg::*;

	function automatic logic signed [EW-1:0] cx(input logic signed [COORD_WIDTH-1:0] c);
		return {c[COORD_WIDTH-1], c};
	endfunction

	function automatic logic signed [PW-1:0] ex(input logic signed [EW-1:0] e);
		return {{(PW-EW){e[EW-1]}}, e};
	endfunction

	logic signed [EW-1:0]   e1_q [3];
	logic signed [EW-1:0]   e2_q [3];
	logic signed [EW-1:0]   tv_q [3];
	logic signed [EW-1:0]   dir_w [3];
	logic signed [PW-1:0]   pv_q [3];
	logic signed [PW-1:0]   qv_q [3];
	logic                   restart_q;
	logic signed [EW-1:0]   mul_a;
	logic signed [PW-1:0]   mul_b;
	logic signed [MW-1:0]   prod_s1;
	logic [ACCW-1:0]        acc_q, acc_d, prod_x, addend;
	logic                   step_first, step_last, step_neg;
	logic [ACCW-1:0]        det_q, tn_q, un_q, vn_q;
	logic [ACCW-1:0]        a_q, t_q, u_q, v_q;
	logic                   hit_w, sat_w, hit_q, sat_q;
	logic [ACCW-1:0]        r_q;
	logic [ACCW:0]          r2_w;
	logic [DW-1:0]          nlow_q, quo_q, dist_w, near_base, near_d;
	logic                   out_valid_q, tri_hit_q, any_hit_q, seen_q;
	logic [DW-1:0]          tri_dist_q, near_out_q, near_q;

	assign dir_w[0] = cx(cfg.dir_x);
	assign dir_w[1] = cx(cfg.dir_y);
	assign dir_w[2] = cx(cfg.dir_z);

	// edges and origin offset of the accepted triangle
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			e1_q[0]   <= cx(v1_x) - cx(v0_x);
			e1_q[1]   <= cx(v1_y) - cx(v0_y);
			e1_q[2]   <= cx(v1_z) - cx(v0_z);
			e2_q[0]   <= cx(v2_x) - cx(v0_x);
			e2_q[1]   <= cx(v2_y) - cx(v0_y);
			e2_q[2]   <= cx(v2_z) - cx(v0_z);
			tv_q[0]   <= cx(cfg.origin_x) - cx(v0_x);
			tv_q[1]   <= cx(cfg.origin_y) - cx(v0_y);
			tv_q[2]   <= cx(cfg.origin_z) - cx(v0_z);
			restart_q <= restart;
		end
	end

	// operand schedule: pvec, qvec, then det, t, u and v numerators
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.mul_step)
			5'd0:  begin mul_a = dir_w[1]; mul_b = ex(e2_q[2]); end
			5'd1:  begin mul_a = dir_w[2]; mul_b = ex(e2_q[1]); end
			5'd2:  begin mul_a = dir_w[2]; mul_b = ex(e2_q[0]); end
			5'd3:  begin mul_a = dir_w[0]; mul_b = ex(e2_q[2]); end
			5'd4:  begin mul_a = dir_w[0]; mul_b = ex(e2_q[1]); end
			5'd5:  begin mul_a = dir_w[1]; mul_b = ex(e2_q[0]); end
			5'd6:  begin mul_a = tv_q[1];  mul_b = ex(e1_q[2]); end
			5'd7:  begin mul_a = tv_q[2];  mul_b = ex(e1_q[1]); end
			5'd8:  begin mul_a = tv_q[2];  mul_b = ex(e1_q[0]); end
			5'd9:  begin mul_a = tv_q[0];  mul_b = ex(e1_q[2]); end
			5'd10: begin mul_a = tv_q[0];  mul_b = ex(e1_q[1]); end
			5'd11: begin mul_a = tv_q[1];  mul_b = ex(e1_q[0]); end
			5'd12: begin mul_a = e1_q[0];  mul_b = pv_q[0]; end
			5'd13: begin mul_a = e1_q[1];  mul_b = pv_q[1]; end
			5'd14: begin mul_a = e1_q[2];  mul_b = pv_q[2]; end
			5'd15: begin mul_a = e2_q[0];  mul_b = qv_q[0]; end
			5'd16: begin mul_a = e2_q[1];  mul_b = qv_q[1]; end
			5'd17: begin mul_a = e2_q[2];  mul_b = qv_q[2]; end
			5'd18: begin mul_a = tv_q[0];  mul_b = pv_q[0]; end
			5'd19: begin mul_a = tv_q[1];  mul_b = pv_q[1]; end
			5'd20: begin mul_a = tv_q[2];  mul_b = pv_q[2]; end
			5'd21: begin mul_a = dir_w[0]; mul_b = qv_q[0]; end
			5'd22: begin mul_a = dir_w[1]; mul_b = qv_q[1]; end
			5'd23: begin mul_a = dir_w[2]; mul_b = qv_q[2]; end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) prod_s1 <= mul_a * mul_b;
	end

	always_comb begin
		step_neg   = 1'b0;
		step_first = 1'b0;
		step_last  = 1'b0;
		if (cmd.acc_step < 5'd12) begin
			step_neg   = cmd.acc_step[0];
			step_first = !cmd.acc_step[0];
			step_last  = cmd.acc_step[0];
		end else begin
			case (cmd.acc_step) inside
				5'd12, 5'd15, 5'd18, 5'd21: step_first = 1'b1;
				5'd14, 5'd17, 5'd20, 5'd23: step_last  = 1'b1;
				default: ;
			endcase
		end
	end

	assign prod_x = {{(ACCW-MW){prod_s1[MW-1]}}, prod_s1};
	assign addend = step_neg ? (ACCW'(0) - prod_x) : prod_x;
	assign acc_d  = (step_first ? ACCW'(0) : acc_q) + addend;

	always_ff @(posedge clk) begin
		if (cmd.acc_en) begin
			acc_q <= acc_d;
			if (step_last) begin
				case (cmd.acc_step)
					5'd1:  pv_q[0] <= acc_d[PW-1:0];
					5'd3:  pv_q[1] <= acc_d[PW-1:0];
					5'd5:  pv_q[2] <= acc_d[PW-1:0];
					5'd7:  qv_q[0] <= acc_d[PW-1:0];
					5'd9:  qv_q[1] <= acc_d[PW-1:0];
					5'd11: qv_q[2] <= acc_d[PW-1:0];
					5'd14: det_q   <= acc_d;
					5'd17: tn_q    <= acc_d;
					5'd20: un_q    <= acc_d;
					5'd23: vn_q    <= acc_d;
					default: ;
				endcase
			end
		end
	end

	// fold the sign of det into the numerators
	always_ff @(posedge clk) begin
		if (cmd.sign_en) begin
			a_q <= det_q[ACCW-1] ? (ACCW'(0) - det_q) : det_q;
			t_q <= det_q[ACCW-1] ? (ACCW'(0) - tn_q)  : tn_q;
			u_q <= det_q[ACCW-1] ? (ACCW'(0) - un_q)  : un_q;
			v_q <= det_q[ACCW-1] ? (ACCW'(0) - vn_q)  : vn_q;
		end
	end

	assign hit_w = (a_q > ACCW'(cfg.det_epsilon)) && !t_q[ACCW-1] && !u_q[ACCW-1]
		&& !v_q[ACCW-1] && ($signed(u_q) <= $signed(a_q))
		&& ($signed(u_q + v_q) <= $signed(a_q));
	// integer part of t beyond the distance range
	assign sat_w = (t_q >> IW) >= a_q;

	assign r2_w = {r_q, nlow_q[DW-1]};

	always_ff @(posedge clk) begin
		if (cmd.check_en) begin
			hit_q  <= hit_w;
			sat_q  <= sat_w;
			r_q    <= t_q >> IW;
			nlow_q <= {t_q[IW-1:0], {DIST_FRAC_BITS{1'b0}}};
			quo_q  <= '0;
		end else if (cmd.div_step) begin
			nlow_q <= nlow_q << 1;
			if (r2_w >= {1'b0, a_q}) begin
				r_q   <= ACCW'(r2_w - {1'b0, a_q});
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				r_q   <= r2_w[ACCW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		if (!hit_q) begin
			dist_w = NO_HIT;
		end else if (sat_q || quo_q == NO_HIT) begin
			dist_w = DIST_SAT;
		end else begin
			dist_w = quo_q;
		end
		near_base = restart_q ? NO_HIT : near_q;
		near_d    = (hit_q && dist_w < near_base) ? dist_w : near_base;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_q      <= NO_HIT;
			seen_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				near_q      <= near_d;
				seen_q      <= hit_q || (!restart_q && seen_q);
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			tri_hit_q  <= hit_q;
			tri_dist_q <= dist_w;
			near_out_q <= near_d;
			any_hit_q  <= hit_q || (!restart_q && seen_q);
		end
	end

	assign sts.hit      = hit_w;
	assign sts.sat      = sat_w;
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid         = out_valid_q;
	assign triangle_hit      = tri_hit_q;
	assign triangle_distance = tri_dist_q;
	assign nearest_distance  = near_out_q;
	assign any_hit           = any_hit_q;

	a_hit_has_dist: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && tri_hit_q |-> tri_dist_q != NO_HIT)
		else $error("hit reported with no-hit distance");

	a_miss_no_dist: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !tri_hit_q |-> tri_dist_q == NO_HIT)
		else $error("miss reported with a distance");

	a_nearest_seen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !any_hit_q |-> near_out_q == NO_HIT)
		else $error("nearest distance set without any hit");

endmodule

/* verif/rtnh_checker.sv */
// ----------------------------------------------------------------------------
// rtnh_checker: result predictor and scoreboard for the nearest hit unit
// Watches the config, triangle and result channels, computes the expected
// hit flag, distance and running nearest state, and counts mismatches.
// ----------------------------------------------------------------------------
module rtnh_checker (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_valid,
	input  logic                                    cfg_ready,
	input  logic [rtnh_pkg::CFG_IDXW-1:0]           cfg_index,
	input  logic [rtnh_pkg::EPSW-1:0]               cfg_data,
	input  logic                                    in_valid,
	input  logic                                    in_ready,
	input  logic                                    restart,
	input  logic signed [rtnh_pkg::COORD_WIDTH-1:0] v0_x,
	input  logic signed [rtnh_pkg::COORD_WIDTH-1:0] v0_y,
	input  logic signed [rtnh_pkg::COORD_WIDTH-1:0] v0_z,
	input  logic signed [rtnh_pkg::COORD_WIDTH-1:0] v1_x,
	input  logic signed [rtnh_pkg::COORD_WIDTH-1:0] v1_y,
	input  logic signed [rtnh_pkg::COORD_WIDTH-1:0] v1_z,
	input  logic signed [rtnh_pkg::COORD_WIDTH-1:0] v2_x,
	input  logic signed [rtnh_pkg::COORD_WIDTH-1:0] v2_y,
	input  logic signed [rtnh_pkg::COORD_WIDTH-1:0] v2_z,
	input  logic                                    out_valid,
	input  logic                                    out_ready,
	input  logic                                    triangle_hit,
	input  logic [rtnh_pkg::DW-1:0]                 triangle_distance,
	input  logic [rtnh_pkg::DW-1:0]                 nearest_distance,
	input  logic                                    any_hit,
	output int                                      errors,
	output int                                      pending,
	output int                                      hits_seen
);
	import rtnh_pkg::*;

	typedef struct {
		logic          hit;
		logic [DW-1:0] distance;
		logic [DW-1:0] nearest;
		logic          any;
	} hit_result_t;

	typedef logic signed [63:0] s64_t;

	hit_result_t  expected_q[$];
	cfg_t         ray;
	logic [DW-1:0] nearest_state;
	logic          seen_state;

	assign pending = expected_q.size();

	// t = n / d with DIST_FRAC_BITS fraction bits, truncated and saturated
	function automatic logic [DW-1:0] distance_of(logic [63:0] n, logic [63:0] d);
		logic [63:0] q;
		logic [63:0] r;
		logic [63:0] res;
		q = n / d;
		r = n % d;
		if (q > (64'(NO_HIT) >> DIST_FRAC_BITS))
			return DIST_SAT;
		res = q;
		for (int i = 0; i < DIST_FRAC_BITS; i++) begin
			res = res << 1;
			if (r >= d - r) begin
				r = r - (d - r);
				res[0] = 1'b1;
			end else begin
				r = r << 1;
			end
		end
		if (res >= 64'(NO_HIT))
			return DIST_SAT;
		return res[DW-1:0];
	endfunction

	function automatic hit_result_t predict_hit(logic rs, s64_t p0[3], s64_t p1[3],
			s64_t p2[3]);
		s64_t org[3], dir[3], e1[3], e2[3], tv[3], pv[3], qv[3];
		s64_t det, tn, un, vn, mag;
		logic hit;
		hit_result_t r;
		org[0] = ray.origin_x; org[1] = ray.origin_y; org[2] = ray.origin_z;
		dir[0] = ray.dir_x; dir[1] = ray.dir_y; dir[2] = ray.dir_z;
		if (rs) begin
			nearest_state = NO_HIT;
			seen_state = 1'b0;
		end
		for (int i = 0; i < 3; i++) begin
			e1[i] = p1[i] - p0[i];
			e2[i] = p2[i] - p0[i];
			tv[i] = org[i] - p0[i];
		end
		pv[0] = dir[1]*e2[2] - dir[2]*e2[1];
		pv[1] = dir[2]*e2[0] - dir[0]*e2[2];
		pv[2] = dir[0]*e2[1] - dir[1]*e2[0];
		qv[0] = tv[1]*e1[2] - tv[2]*e1[1];
		qv[1] = tv[2]*e1[0] - tv[0]*e1[2];
		qv[2] = tv[0]*e1[1] - tv[1]*e1[0];
		det = e1[0]*pv[0] + e1[1]*pv[1] + e1[2]*pv[2];
		tn = e2[0]*qv[0] + e2[1]*qv[1] + e2[2]*qv[2];
		un = tv[0]*pv[0] + tv[1]*pv[1] + tv[2]*pv[2];
		vn = dir[0]*qv[0] + dir[1]*qv[1] + dir[2]*qv[2];
		mag = det;
		if (det < 0) begin
			mag = -det;
			tn = -tn;
			un = -un;
			vn = -vn;
		end
		hit = ($unsigned(mag) > 64'(ray.det_epsilon)) && tn >= 0 && un >= 0 &&
			un <= mag && vn >= 0 && (un + vn) <= mag;
		r.hit = hit;
		r.distance = NO_HIT;
		if (hit) begin
			r.distance = distance_of(tn, mag);
			if (r.distance < nearest_state)
				nearest_state = r.distance;
			seen_state = 1'b1;
		end
		r.nearest = nearest_state;
		r.any = seen_state;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ray = '0;
			ray.dir_z = 16'sd256;
			ray.det_epsilon = 48'd17;
			nearest_state = NO_HIT;
			seen_state = 1'b0;
			errors = 0;
			hits_seen = 0;
			expected_q.delete();
		end else begin
			// results first: a request accepted now cannot finish in the same cycle
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result hit=%0b dist=%h", $time, triangle_hit,
						triangle_distance);
					errors++;
				end else begin
					hit_result_t e;
					e = expected_q.pop_front();
					if (triangle_hit) hits_seen++;
					if (e.hit !== triangle_hit || e.distance !== triangle_distance ||
							e.nearest !== nearest_distance || e.any !== any_hit) begin
						$display("%0t: mismatch expected hit=%0b dist=%h near=%h any=%0b",
							$time, e.hit, e.distance, e.nearest, e.any);
						$display("%0t:          actual   hit=%0b dist=%h near=%h any=%0b",
							$time, triangle_hit, triangle_distance, nearest_distance,
							any_hit);
						errors++;
					end
				end
			end
			if (in_valid && in_ready) begin
				s64_t p0[3], p1[3], p2[3];
				p0[0] = v0_x; p0[1] = v0_y; p0[2] = v0_z;
				p1[0] = v1_x; p1[1] = v1_y; p1[2] = v1_z;
				p2[0] = v2_x; p2[1] = v2_y; p2[2] = v2_z;
				expected_q.push_back(predict_hit(restart, p0, p1, p2));
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_ORIGIN_X: ray.origin_x = cfg_data[COORD_WIDTH-1:0];
					CFG_ORIGIN_Y: ray.origin_y = cfg_data[COORD_WIDTH-1:0];
					CFG_ORIGIN_Z: ray.origin_z = cfg_data[COORD_WIDTH-1:0];
					CFG_DIR_X:    ray.dir_x = cfg_data[COORD_WIDTH-1:0];
					CFG_DIR_Y:    ray.dir_y = cfg_data[COORD_WIDTH-1:0];
					CFG_DIR_Z:    ray.dir_z = cfg_data[COORD_WIDTH-1:0];
					CFG_DET_EPS:  ray.det_epsilon = cfg_data;
					default: ;
				endcase
			end
		end
	end

endmodule

/* verif/tb_ray_triangle_nearest_hit_unit.sv */
// ----------------------------------------------------------------------------
// tb_ray_triangle_nearest_hit_unit: testbench of the nearest hit unit
// Sends directed and random triangles over several ray settings with random
// stalls on both sides; a checker module predicts and compares each result.
// ----------------------------------------------------------------------------
module tb_ray_triangle_nearest_hit_unit;
	import rtnh_pkg::*;

	localparam int NUM_RANDOM = 1930;
	localparam int CYCLE_LIMIT = 900000;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [CFG_IDXW-1:0]           cfg_index = '0;
	logic [EPSW-1:0]               cfg_data = '0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic                          restart = 1'b0;
	logic signed [COORD_WIDTH-1:0] v0_x = '0, v0_y = '0, v0_z = '0;
	logic signed [COORD_WIDTH-1:0] v1_x = '0, v1_y = '0, v1_z = '0;
	logic signed [COORD_WIDTH-1:0] v2_x = '0, v2_y = '0, v2_z = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic                          triangle_hit;
	logic [DW-1:0]                 triangle_distance;
	logic [DW-1:0]                 nearest_distance;
	logic                          any_hit;
	int                            errors, pending, hits_seen;
	int                            cycles = 0;
	int                            sent = 0;
	bit                            calm = 1'b0;
	bit                            hold_off = 1'b0;

	always #1 clk = ~clk;

	ray_triangle_nearest_hit_unit dut (.*);

	rtnh_checker u_checker (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// receiver: random stall bursts, one long hold-off, none near the end
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_off = 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 14);
				out_ready <= 1'b0;
				repeat (gap - 1) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// leaves cfg_valid high; the caller drops it after the last write
	task automatic write_reg(cfg_idx_t idx, logic [EPSW-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic set_ray(logic [15:0] ox, logic [15:0] oy, logic [15:0] oz,
			logic [15:0] dx, logic [15:0] dy, logic [15:0] dz, logic [EPSW-1:0] eps);
		write_reg(CFG_ORIGIN_X, 48'(ox));
		write_reg(CFG_ORIGIN_Y, 48'(oy));
		write_reg(CFG_ORIGIN_Z, 48'(oz));
		write_reg(CFG_DIR_X, 48'(dx));
		write_reg(CFG_DIR_Y, 48'(dy));
		write_reg(CFG_DIR_Z, 48'(dz));
		write_reg(CFG_DET_EPS, eps);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain;
		while (pending != 0) @(posedge clk);
		repeat (70) @(posedge clk);
	endtask

	task automatic send_triangle(logic rs, logic [15:0] a[9]);
		int gap;
		if (!calm && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 14);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		restart <= rs;
		v0_x <= a[0]; v0_y <= a[1]; v0_z <= a[2];
		v1_x <= a[3]; v1_y <= a[4]; v1_z <= a[5];
		v2_x <= a[6]; v2_y <= a[7]; v2_z <= a[8];
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent++;
	endtask

	task automatic finish_burst;
		in_valid <= 1'b0;
	endtask

	// small coordinate that often lands near the ray
	function automatic logic [15:0] near_coord(int span);
		return 16'($signed($urandom_range(0, 2 * span)) - span);
	endfunction

	// random triangle: mode 0 uses any coordinates, mode 1 a wide one around the z axis
	task automatic random_triangle(int mode);
		logic [15:0] a[9];
		int span;
		span = ($urandom_range(0, 9) == 0) ? 32767 : 1024;
		for (int i = 0; i < 9; i++)
			a[i] = (mode == 0) ? 16'($urandom) : near_coord(span);
		if (mode == 1) begin
			// wide triangle straddling the z axis
			a[0] = 16'(-$signed(16'($urandom_range(64, 2048))));
			a[1] = 16'(-$signed(16'($urandom_range(64, 2048))));
			a[3] = 16'($urandom_range(64, 2048));
			a[4] = 16'(-$signed(16'($urandom_range(64, 2048))));
			a[6] = near_coord(512);
			a[7] = 16'($urandom_range(64, 2048));
		end
		send_triangle($urandom_range(0, 7) == 0, a);
	endtask

	initial begin
		logic [15:0] t[9];
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset ray straight up the z axis
		t = '{16'hff00, 16'hff00, 16'h0100, 16'h0100, 16'hff00, 16'h0100,
			16'h0000, 16'h0100, 16'h0100};
		send_triangle(1'b1, t);
		t = '{16'hff00, 16'hff00, 16'h0080, 16'h0100, 16'hff00, 16'h0080,
			16'h0000, 16'h0100, 16'h0080};
		send_triangle(1'b0, t);                       // nearer hit
		t = '{16'hff00, 16'hff00, 16'hff00, 16'h0100, 16'hff00, 16'hff00,
			16'h0000, 16'h0100, 16'hff00};
		send_triangle(1'b0, t);                       // behind the origin
		t = '{16'h0100, 16'h0100, 16'h0100, 16'h0200, 16'h0100, 16'h0100,
			16'h0100, 16'h0200, 16'h0100};
		send_triangle(1'b0, t);                       // off to the side
		t = '{16'h0000, 16'h0000, 16'h0100, 16'h0100, 16'h0000, 16'h0100,
			16'h0000, 16'h0100, 16'h0100};
		send_triangle(1'b0, t);                       // ray through a vertex
		t = '{16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff,
			16'h0000, 16'h7fff, 16'h7fff};
		send_triangle(1'b0, t);                       // extreme coordinates
		t = '{16'h0001, 16'hffff, 16'h7fff, 16'hffff, 16'hffff, 16'h7fff,
			16'h0000, 16'h0001, 16'h7fff};
		send_triangle(1'b1, t);                       // tiny triangle, far away
		t = '{16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h0000, 16'h0100,
			16'h0000, 16'h0000, 16'h0100};
		send_triangle(1'b0, t);                       // degenerate, det zero
		t = '{16'hffff, 16'hffff, 16'h0000, 16'h0001, 16'hffff, 16'h0000,
			16'h0000, 16'h0001, 16'h0000};
		send_triangle(1'b0, t);                       // hit at t zero
		finish_burst();
		drain();

		// tiny direction along z, so the distances come out large
		set_ray(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0001, 48'd0);
		t = '{16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff,
			16'h0000, 16'h7fff, 16'h7fff};
		send_triangle(1'b1, t);
		t = '{16'hff00, 16'hff00, 16'h0100, 16'h0100, 16'hff00, 16'h0100,
			16'h0000, 16'h0100, 16'h0100};
		send_triangle(1'b0, t);
		finish_burst();
		drain();

		// extreme origin and direction, maximal epsilon rejects all
		set_ray(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, '1);
		for (int i = 0; i < 6; i++) random_triangle(0);
		finish_burst();
		drain();
		write_reg(CFG_DET_EPS, 48'd0);
		cfg_valid <= 1'b0;
		for (int i = 0; i < 6; i++) random_triangle(0);
		finish_burst();
		drain();

		// random phases over several rays
		for (int ph = 0; ph < 8; ph++) begin
			if (ph == 7) calm = 1'b1;
			case (ph % 4)
				0: set_ray(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0100,
					48'd17);
				1: set_ray(near_coord(128), near_coord(128), 16'hfc00,
					near_coord(64), near_coord(64), 16'($urandom_range(1, 32767)),
					48'($urandom_range(0, 4096)));
				2: set_ray(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom), {16'($urandom), 32'($urandom)});
				default: set_ray(16'h0000, 16'h0000, 16'h8000, 16'h0000, 16'h0000,
					16'h7fff, 48'd1);
			endcase
			if (ph == 2) hold_off = 1'b1;
			for (int i = 0; i < NUM_RANDOM / 8; i++)
				random_triangle(($urandom_range(0, 9) < 7) ? 1 : 0);
			finish_burst();
			drain();
		end

		$display("sent %0d triangles over 8 random ray settings plus directed cases,",
			sent);
		$display("%0d of them hit; result errors: %0d", hits_seen, errors);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* ray_triangle_nearest_hit_unit.f */
rtl/rtnh_pkg.sv
rtl/rtnh_cfg.sv
rtl/rtnh_ctrl.sv
rtl/rtnh_dp.sv
rtl/ray_triangle_nearest_hit_unit.sv
verif/rtnh_checker.sv
verif/tb_ray_triangle_nearest_hit_unit.sv
